[design/twc_pkg.sv]
// Shared types and constants for the text console character writer.
// No dependencies; imported by every design and bench file except the two interfaces.
package twc_pkg;

    localparam int TWC_MAX_COLS    = 128;
    localparam int TWC_MAX_ROWS    = 32;
    localparam int TWC_TAB_STOP    = 8;
    localparam int TWC_QUEUE_DEPTH = 2;

    // register indexes on the config port
    localparam logic [1:0] REG_COLUMNS     = 2'd0;
    localparam logic [1:0] REG_ROWS        = 2'd1;
    localparam logic [1:0] REG_DEFAULT_ATR = 2'd2;
    localparam logic [1:0] REG_PASSTHROUGH = 2'd3;

    localparam logic [7:0] RST_COLUMNS = 8'd80;
    localparam logic [5:0] RST_ROWS    = 6'd25;
    localparam logic [7:0] RST_ATTR    = 8'd7;

    localparam logic [7:0] CH_BELL  = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [2:0] {
        K_PUT  = 3'd0,
        K_READ = 3'd1,
        K_BELL = 3'd2,
        K_BS   = 3'd3,
        K_TAB  = 3'd4,
        K_CR   = 3'd5,
        K_LF   = 3'd6
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic [4:0] rrow;
        logic [6:0] rcol;
    } t_cmd;

    typedef struct packed {
        logic [7:0] columns;
        logic [5:0] rows;
        logic [7:0] attr;
        logic       pass;
    } t_cfg;

endpackage

[design/twc_in_if.sv]
// Input channel of the console writer: valid/ready plus one character item.
// Stand-alone interface, no package dependency.
interface twc_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, opcode, char_code, read_row, read_col, input ready);
    modport sink   (input valid, opcode, char_code, read_row, read_col, output ready);
endinterface

[design/twc_out_if.sv]
// Result channel of the console writer: valid/ready plus one result beat.
// Stand-alone interface, no package dependency.
interface twc_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic [11:0] cursor_offset;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic        serial_valid;
    logic [7:0]  serial_byte;
    logic        last;

    modport source (output valid, cursor_row, cursor_col, cursor_offset, cell_char,
                    cell_attr, serial_valid, serial_byte, last, input ready);
    modport sink   (input valid, cursor_row, cursor_col, cursor_offset, cell_char,
                    cell_attr, serial_valid, serial_byte, last, output ready);
endinterface

[design/twc_front.sv]
// Front end: takes input beats and decodes them into command kinds.
// Depends on twc_pkg and twc_in_if.
module twc_front (
    twc_in_if.sink      i_in,
    input  logic        i_full,
    output logic        o_push,
    output twc_pkg::t_cmd o_cmd
);
    import twc_pkg::*;

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_cmd.ch   = i_in.char_code;
        o_cmd.rrow = i_in.read_row;
        o_cmd.rcol = i_in.read_col;
        if (i_in.opcode == OP_READ) begin
            o_cmd.kind = K_READ;
        end else begin
            unique case (i_in.char_code)
                CH_BELL: o_cmd.kind = K_BELL;
                CH_BS:   o_cmd.kind = K_BS;
                CH_TAB:  o_cmd.kind = K_TAB;
                CH_CR:   o_cmd.kind = K_CR;
                CH_LF:   o_cmd.kind = K_LF;
                default: o_cmd.kind = K_PUT;
            endcase
        end
    end
endmodule

[design/twc_queue.sv]
// Short command queue between front end and back end.
// Depends on twc_pkg.
module twc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  twc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output twc_pkg::t_cmd o_head
);
    import twc_pkg::*;

    localparam int PW = (TWC_QUEUE_DEPTH > 1) ? $clog2(TWC_QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(TWC_QUEUE_DEPTH + 1);

    t_cmd          r_mem [TWC_QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    assign o_full  = (r_cnt == NW'(TWC_QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        if (p == PW'(TWC_QUEUE_DEPTH - 1)) return '0;
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ptr_inc(r_wp);
            if (i_pop)  r_rp <= ptr_inc(r_rp);
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end
endmodule

[design/twc_back.sv]
// Back end: cursor, cell store, scroll and clear sequencer, result register.
// Depends on twc_pkg and twc_out_if.
module twc_back #(
    parameter int MAX_COLS = twc_pkg::TWC_MAX_COLS,
    parameter int MAX_ROWS = twc_pkg::TWC_MAX_ROWS,
    parameter int TAB_STOP = twc_pkg::TWC_TAB_STOP
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  twc_pkg::t_cfg i_cfg,
    input  twc_pkg::t_cmd i_head,
    input  logic          i_empty,
    output logic          o_pop,
    twc_out_if.source     o_out
);
    import twc_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = RW + CW;
    localparam int TW    = $clog2(TAB_STOP + 1);
    localparam int OW    = AW + 2;
    localparam int RECIP = (65536 + TAB_STOP - 1) / TAB_STOP;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_RDATA = 8'b00000100,
        S_WRITE = 8'b00001000,
        S_SC_RD = 8'b00010000,
        S_SC_WR = 8'b00100000,
        S_BLANK = 8'b01000000,
        S_EMIT  = 8'b10000000
    } t_state;

    logic [15:0] mem [2**AW];
    logic [15:0] r_rdata;

    t_state        r_state, n_state;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_clr, n_clr;
    logic          r_ov, n_ov;
    logic          r_two, n_two;
    logic [TW-1:0] r_t, n_t;
    logic [7:0]    r_wch, n_wch;
    logic [RW-1:0] r_sr, n_sr;
    logic [CW-1:0] r_sc, n_sc;
    logic          r_inr, n_inr;
    logic [7:0]    r_cc, n_cc, r_ca, n_ca, r_sb, n_sb;
    logic          r_sv, n_sv;

    logic [4:0]  r_o_row;
    logic [6:0]  r_o_col;
    logic [11:0] r_o_off;
    logic [7:0]  r_o_cc, r_o_ca, r_o_sb;
    logic        r_o_sv, r_o_last;
    logic        load;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata;

    logic [CW:0]   nc, nc_m1;
    logic [RW:0]   nr, nr_m1;
    logic [RW-1:0] srow;
    logic [CW-1:0] scol;
    logic [CW:0]   ncol_w;
    logic [24:0]   tab_prod;
    logic [8:0]    tab_q, tab_rem;
    logic [OW-1:0] off_full;
    logic [31:0]   off32, row32, col32, rr32, rc32;
    logic          rd_in;
    logic          last_copy_row;

    // used area, saturated to 1..MAX
    always_comb begin
        if (i_cfg.columns == '0)                  nc = (CW+1)'(1);
        else if (9'(i_cfg.columns) > 9'(MAX_COLS)) nc = (CW+1)'(MAX_COLS);
        else                                      nc = (CW+1)'(i_cfg.columns);
        if (i_cfg.rows == '0)                     nr = (RW+1)'(1);
        else if (7'(i_cfg.rows) > 7'(MAX_ROWS))   nr = (RW+1)'(MAX_ROWS);
        else                                      nr = (RW+1)'(i_cfg.rows);
        nc_m1 = nc - 1'b1;
        nr_m1 = nr - 1'b1;
    end

    // cursor clamped into the used area
    assign srow = ({1'b0, r_row} > nr_m1) ? nr_m1[RW-1:0] : r_row;
    assign scol = ({1'b0, r_col} > nc_m1) ? nc_m1[CW-1:0] : r_col;

    // distance to next tab stop; remainder by reciprocal multiply
    assign tab_prod = 25'(scol) * 25'(RECIP);
    assign tab_q    = tab_prod[24:16];
    assign tab_rem  = 9'(scol) - 9'(tab_q * TAB_STOP);

    assign ncol_w        = {1'b0, r_col} + 1'b1;
    assign last_copy_row = ({1'b0, r_sr} + 2'd2) == nr;

    assign rr32  = 32'(i_head.rrow);
    assign rc32  = 32'(i_head.rcol);
    assign rd_in = (rr32 < 32'(nr)) && (rc32 < 32'(nc));

    assign off_full = OW'(r_row) * OW'(nc) + OW'(r_col);
    assign off32    = 32'(off_full);
    assign row32    = 32'(r_row);
    assign col32    = 32'(r_col);
    assign load     = (r_state == S_EMIT) && (!r_ov || o_out.ready);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_clr   = r_clr;
        n_two   = r_two;
        n_t     = r_t;
        n_wch   = r_wch;
        n_sr    = r_sr;
        n_sc    = r_sc;
        n_inr   = r_inr;
        n_cc    = r_cc;
        n_ca    = r_ca;
        n_sv    = r_sv;
        n_sb    = r_sb;
        o_pop   = 1'b0;
        we      = 1'b0;
        waddr   = {r_row, r_col};
        wdata   = {i_cfg.attr, r_wch};
        raddr   = {rr32[RW-1:0], rc32[CW-1:0]};

        n_ov = r_ov;
        if (load)             n_ov = 1'b1;
        else if (o_out.ready) n_ov = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cc  = '0;
                    n_ca  = '0;
                    n_sv  = 1'b0;
                    n_sb  = '0;
                    n_two = 1'b0;
                    if (i_head.kind == K_READ) begin
                        n_inr   = rd_in;
                        n_state = S_RDATA;
                    end else if (i_cfg.pass) begin
                        n_sv    = 1'b1;
                        n_state = S_EMIT;
                        if (i_head.kind == K_LF) begin
                            n_sb  = CH_CR;
                            n_two = 1'b1;
                        end else begin
                            n_sb = i_head.ch;
                        end
                    end else begin
                        n_row   = srow;
                        n_col   = scol;
                        n_state = S_EMIT;
                        n_sr    = '0;
                        n_sc    = '0;
                        unique case (i_head.kind)
                            K_BS: begin
                                if (scol != '0) begin
                                    n_col = scol - 1'b1;
                                end else if (srow != '0) begin
                                    n_row = srow - 1'b1;
                                    n_col = nc_m1[CW-1:0];
                                end
                            end
                            K_CR: n_col = '0;
                            K_LF: begin
                                n_col = '0;
                                n_t   = '0;
                                if ({1'b0, srow} == nr_m1) begin
                                    n_state = (nr == (RW+1)'(1)) ? S_BLANK : S_SC_RD;
                                end else begin
                                    n_row = srow + 1'b1;
                                end
                            end
                            K_TAB: begin
                                n_t     = TW'(TAB_STOP) - TW'(tab_rem);
                                n_wch   = CH_SPACE;
                                n_state = S_WRITE;
                            end
                            K_PUT: begin
                                n_t     = TW'(1);
                                n_wch   = i_head.ch;
                                n_state = S_WRITE;
                            end
                            default: ;   // bell: clamp only
                        endcase
                    end
                end
            end
            S_RDATA: begin
                n_cc    = r_inr ? r_rdata[7:0]  : 8'h00;
                n_ca    = r_inr ? r_rdata[15:8] : 8'h00;
                n_state = S_EMIT;
            end
            S_WRITE: begin
                we  = 1'b1;
                n_t = r_t - 1'b1;
                n_sr = '0;
                n_sc = '0;
                if (ncol_w >= nc) begin
                    n_col = '0;
                    if ({1'b0, r_row} == nr_m1) begin
                        n_state = (nr == (RW+1)'(1)) ? S_BLANK : S_SC_RD;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_state = (n_t == '0) ? S_EMIT : S_WRITE;
                    end
                end else begin
                    n_col   = ncol_w[CW-1:0];
                    n_state = (n_t == '0) ? S_EMIT : S_WRITE;
                end
            end
            S_SC_RD: begin
                raddr   = {r_sr + 1'b1, r_sc};
                n_state = S_SC_WR;
            end
            S_SC_WR: begin
                we    = 1'b1;
                waddr = {r_sr, r_sc};
                wdata = r_rdata;
                if ({1'b0, r_sc} == nc_m1) begin
                    n_sc    = '0;
                    n_sr    = r_sr + 1'b1;
                    n_state = last_copy_row ? S_BLANK : S_SC_RD;
                end else begin
                    n_sc    = r_sc + 1'b1;
                    n_state = S_SC_RD;
                end
            end
            S_BLANK: begin
                we    = 1'b1;
                waddr = {nr_m1[RW-1:0], r_sc};
                wdata = {i_cfg.attr, CH_SPACE};
                if ({1'b0, r_sc} == nc_m1) begin
                    n_sc    = '0;
                    n_state = (r_t != '0) ? S_WRITE : S_EMIT;
                end else begin
                    n_sc = r_sc + 1'b1;
                end
            end
            S_EMIT: begin
                if (load) begin
                    if (r_two) begin
                        n_two = 1'b0;
                        n_sb  = CH_LF;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rdata <= mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_row   <= '0;
            r_col   <= '0;
            r_clr   <= '0;
            r_ov    <= 1'b0;
            r_two   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_clr   <= n_clr;
            r_ov    <= n_ov;
            r_two   <= n_two;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t   <= n_t;
        r_wch <= n_wch;
        r_sr  <= n_sr;
        r_sc  <= n_sc;
        r_inr <= n_inr;
        r_cc  <= n_cc;
        r_ca  <= n_ca;
        r_sv  <= n_sv;
        r_sb  <= n_sb;
        if (load) begin
            r_o_row  <= row32[4:0];
            r_o_col  <= col32[6:0];
            r_o_off  <= off32[11:0];
            r_o_cc   <= r_cc;
            r_o_ca   <= r_ca;
            r_o_sv   <= r_sv;
            r_o_sb   <= r_sb;
            r_o_last <= !r_two;
        end
    end

    assign o_out.valid         = r_ov;
    assign o_out.cursor_row    = r_o_row;
    assign o_out.cursor_col    = r_o_col;
    assign o_out.cursor_offset = r_o_off;
    assign o_out.cell_char     = r_o_cc;
    assign o_out.cell_attr     = r_o_ca;
    assign o_out.serial_valid  = r_o_sv;
    assign o_out.serial_byte   = r_o_sb;
    assign o_out.last          = r_o_last;
endmodule

[design/text_console_char_writer_unit.sv]
// Top level of the text console character writer: config registers, front end,
// command queue and back end. Depends on twc_pkg, twc_in_if, twc_out_if.
//
// One beat in = one character put or one cell read. Results leave on o_out,
// one beat per item (two for LF in passthrough: CR, then LF; last marks the
// final one). After reset the cell store (MAX_ROWS x MAX_COLS rounded up to
// powers of two, 4096 cells by default) is swept to zero, one cell per clock;
// input beats queue up meanwhile until the queue is full, and config writes
// are taken at any time. In the back end a put writes one cell and a tab up
// to TAB_STOP cells. A scroll copies the used area cell by cell, each moved
// cell read in S_SC_RD and written one row up in S_SC_WR, then blanks the
// bottom row in S_BLANK; input stalls once the queue is full. The front end
// decodes and queues commands, so input beats keep being taken while the back
// end works or while a result waits, until the queue is full.
// Config must be written only with the block idle, by the user; the block
// itself does not enforce this.
module text_console_char_writer_unit #(
    parameter int MAX_COLS = twc_pkg::TWC_MAX_COLS,
    parameter int MAX_ROWS = twc_pkg::TWC_MAX_ROWS,
    parameter int TAB_STOP = twc_pkg::TWC_TAB_STOP
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    twc_in_if.sink     i_in,
    twc_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata
);
    import twc_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd, q_head;
    logic front_push, q_full, q_empty, back_pop;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.columns <= RST_COLUMNS;
            r_cfg.rows    <= RST_ROWS;
            r_cfg.attr    <= RST_ATTR;
            r_cfg.pass    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_COLUMNS:     r_cfg.columns <= i_cfg_wdata;
                REG_ROWS:        r_cfg.rows    <= i_cfg_wdata[5:0];
                REG_DEFAULT_ATR: r_cfg.attr    <= i_cfg_wdata;
                REG_PASSTHROUGH: r_cfg.pass    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    twc_front u_front (
        .i_in   (i_in),
        .i_full (q_full),
        .o_push (front_push),
        .o_cmd  (front_cmd)
    );

    twc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    twc_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_head  (q_head),
        .i_empty (q_empty),
        .o_pop   (back_pop),
        .o_out   (o_out)
    );
endmodule

[verif/twc_tb_pkg.sv]
// Testbench-side helpers for the text console writer bench.
// Depends on twc_pkg for the control-code constants.
package twc_tb_pkg;
    import twc_pkg::*;

    typedef struct packed {
        logic [4:0]  row;
        logic [6:0]  col;
        logic [11:0] offset;
        logic [7:0]  cchar;
        logic [7:0]  cattr;
        logic        sval;
        logic [7:0]  sbyte;
        logic        last;
    } t_beat;
endpackage

[verif/text_console_char_writer_unit_tb.sv]
// Self-checking bench for text_console_char_writer_unit: drives character puts
// and cell reads, predicts cursor/cell/serial beats with a local screen model.
// Depends on twc_pkg, twc_tb_pkg, twc_in_if, twc_out_if and the DUT.
module text_console_char_writer_unit_tb;
    import twc_pkg::*;
    import twc_tb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [7:0] i_cfg_wdata = '0;

    twc_in_if  in_ch();
    twc_out_if out_ch();

    text_console_char_writer_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---- console model: config copy, cursor and cell store ----
    int unsigned cfg_cols, cfg_rows, cfg_attr, cfg_pass;
    int unsigned crow, ccol;
    logic [15:0] cells [TWC_MAX_ROWS*TWC_MAX_COLS];

    t_beat expected_beats[$];
    int errors = 0;
    int send_idle_pct = 0;   // percent of cycles the sender holds back
    int recv_idle_pct = 0;   // percent of cycles the receiver stalls
    longint cycles = 0;

    function automatic int unsigned live_cols();
        return (cfg_cols < 1) ? 1 : (cfg_cols > TWC_MAX_COLS ? TWC_MAX_COLS : cfg_cols);
    endfunction

    function automatic int unsigned live_rows();
        return (cfg_rows < 1) ? 1 : (cfg_rows > TWC_MAX_ROWS ? TWC_MAX_ROWS : cfg_rows);
    endfunction

    function automatic void write_cell(int unsigned r, int unsigned c, logic [7:0] ch);
        cells[r*TWC_MAX_COLS + c] = {cfg_attr[7:0], ch};
    endfunction

    function automatic void push_beat(logic [7:0] cch, logic [7:0] cat,
                                      logic sv, logic [7:0] sb, logic lst);
        t_beat b;
        int unsigned off;
        off = crow * live_cols() + ccol;
        b.row = crow[4:0]; b.col = ccol[6:0]; b.offset = off[11:0];
        b.cchar = cch; b.cattr = cat; b.sval = sv; b.sbyte = sb; b.last = lst;
        expected_beats.push_back(b);
    endfunction

    // screen-mode put: moves the cursor, writes cells, scrolls
    function automatic void console_put(logic [7:0] ch_in);
        int unsigned nc, nr, t, n;
        logic [7:0] ch;
        nc = live_cols(); nr = live_rows(); t = 0; ch = ch_in;
        if (crow >= nr) crow = nr - 1;
        if (ccol >= nc) ccol = nc - 1;
        case (ch_in)
            CH_BELL: return;
            CH_BS: begin
                if (ccol != 0) ccol--;
                else if (crow != 0) begin
                    crow--; ccol = nc - 1;
                end
                return;
            end
            CH_TAB: begin
                t = TWC_TAB_STOP - (ccol % TWC_TAB_STOP);
                ch = CH_SPACE;
            end
            CH_CR: begin
                ccol = 0;
                return;
            end
            CH_LF: ccol = nc;
            default: t = 1;
        endcase
        do begin
            n = nc - ccol;
            if (t < n) n = t;
            if (t != 0) begin
                for (int i = 0; i < n; i++) write_cell(crow, ccol + i, ch);
                ccol += n;
            end
            if (ccol >= nc) begin
                ccol = 0; crow++;
            end
            if (crow >= nr) begin
                crow = nr - 1;
                // scroll used area up one row, blank the bottom
                for (int r = 0; r + 1 < nr; r++)
                    for (int c = 0; c < nc; c++)
                        cells[r*TWC_MAX_COLS + c] = cells[(r+1)*TWC_MAX_COLS + c];
                for (int c = 0; c < nc; c++) write_cell(nr - 1, c, CH_SPACE);
            end
            t -= n;
        end while (t != 0);
    endfunction

    function automatic void predict_item(logic op, logic [7:0] ch,
                                         logic [4:0] rr, logic [6:0] rc);
        logic [15:0] v;
        if (op == OP_READ) begin
            v = (rr < live_rows() && rc < live_cols()) ? cells[rr*TWC_MAX_COLS + rc] : '0;
            push_beat(v[7:0], v[15:8], 1'b0, 8'h00, 1'b1);
        end else if (cfg_pass != 0) begin
            if (ch == CH_LF) begin
                push_beat(8'h00, 8'h00, 1'b1, CH_CR, 1'b0);
                push_beat(8'h00, 8'h00, 1'b1, CH_LF, 1'b1);
            end else begin
                push_beat(8'h00, 8'h00, 1'b1, ch, 1'b1);
            end
        end else begin
            console_put(ch);
            push_beat(8'h00, 8'h00, 1'b0, 8'h00, 1'b1);
        end
    endfunction

    // ---- drive one input beat; prediction taken at acceptance ----
    // valid stays high after the beat so back-to-back items need no gap
    task automatic send_item(logic op, logic [7:0] ch, logic [4:0] rr, logic [6:0] rc);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op; in_ch.char_code <= ch;
        in_ch.read_row <= rr; in_ch.read_col <= rc;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        predict_item(op, ch, rr, rc);
        @(negedge i_clk);
    endtask

    // ---- result checker ----
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_beat got, want;
            got = '{out_ch.cursor_row, out_ch.cursor_col, out_ch.cursor_offset,
                    out_ch.cell_char, out_ch.cell_attr, out_ch.serial_valid,
                    out_ch.serial_byte, out_ch.last};
            if (expected_beats.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = expected_beats.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // receiver stall pattern, updated at the falling edge
    always @(negedge i_clk)
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 20_000_000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---- helpers shared by the tests ----
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        // every item gives at least one beat, so an empty list means nothing in flight
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_COLUMNS:     cfg_cols = val;
            REG_ROWS:        cfg_rows = val[5:0];
            REG_DEFAULT_ATR: cfg_attr = val;
            REG_PASSTHROUGH: cfg_pass = val[0];
            default: ;
        endcase
    endtask

    task automatic set_screen(int unsigned c, int unsigned r, int unsigned a, int unsigned p);
        wait_drained();
        write_reg(REG_COLUMNS, c[7:0]);
        write_reg(REG_ROWS, r[7:0]);
        write_reg(REG_DEFAULT_ATR, a[7:0]);
        write_reg(REG_PASSTHROUGH, p[7:0]);
    endtask

    task automatic put_ch(logic [7:0] ch);
        send_item(OP_PUT, ch, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_cell(logic [4:0] r, logic [6:0] c);
        send_item(OP_READ, 8'($urandom), r, c);
    endtask

    // random character, weighted toward control codes and printables
    function automatic logic [7:0] pick_char();
        case ($urandom_range(9))
            0: return CH_LF;
            1: return CH_TAB;
            2: return CH_BS;
            3: return CH_CR;
            4: return CH_BELL;
            5: return 8'($urandom);
            default: return 8'(8'h20 + $urandom_range(94));
        endcase
    endfunction

    // ---- tests ----
    task automatic test_directed_controls();
        // reset geometry 80x25; controls, extremes, reads in and out of area
        put_ch(8'h41); put_ch(8'h00); put_ch(8'hFF);
        put_ch(CH_BELL); put_ch(CH_TAB); put_ch(CH_BS); put_ch(CH_CR);
        put_ch(CH_BS); put_ch(CH_LF); put_ch(CH_BS); put_ch(CH_LF);
        read_cell(0, 0); read_cell(0, 1); read_cell(0, 2); read_cell(0, 9);
        read_cell(31, 127); read_cell(24, 79); read_cell(25, 0);
    endtask

    task automatic test_wrap_and_scroll();
        // small screen: wrap on last column, scroll at bottom, tab spill
        set_screen(10, 3, 8'hA5, 0);
        for (int i = 0; i < 40; i++) put_ch((i % 4 == 0) ? CH_TAB : 8'(8'h30 + i));
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 11; c += 3) read_cell(5'(r), 7'(c));
    endtask

    task automatic test_passthrough();
        set_screen(80, 25, 8'h00, 1);
        put_ch(CH_LF); put_ch(CH_CR); put_ch(8'hFF); put_ch(8'h00);
        read_cell(0, 0);
        for (int i = 0; i < 30; i++) put_ch(pick_char());
    endtask

    task automatic test_extreme_geometry();
        // register zero saturates to one; over-range saturates to the maximum
        set_screen(0, 0, 8'hFF, 0);
        for (int i = 0; i < 12; i++) put_ch(pick_char());
        read_cell(0, 0); read_cell(1, 1);
        set_screen(255, 63, 8'h5A, 0);
        for (int i = 0; i < 20; i++) put_ch(pick_char());
        read_cell(31, 127); read_cell(0, 0);
        // shrink while the cursor sits far out: saturation before put
        set_screen(128, 32, 8'h3C, 0);
        for (int i = 0; i < 40; i++) put_ch(CH_LF);
        set_screen(5, 2, 8'h81, 0);
        put_ch(8'h58); read_cell(1, 4); read_cell(0, 0);
    endtask

    task automatic random_phase(int n, int unsigned c, int unsigned r, int unsigned p);
        set_screen(c, r, $urandom, p);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                read_cell(5'($urandom_range(r > 31 ? 31 : r)),
                          7'($urandom_range(c > 127 ? 127 : c)));
            else if ($urandom_range(19) == 0)
                read_cell(5'($urandom), 7'($urandom));
            else
                put_ch(pick_char());
        end
    endtask

    task automatic test_random();
        // mostly small screens so scrolls stay cheap; a few full-size ones
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 4) begin
                send_idle_pct = 86; recv_idle_pct = 16;
            end
            if (ph == 8) begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            case (ph % 4)
                0: random_phase(150, $urandom_range(1, 16), $urandom_range(1, 6), 0);
                1: random_phase(150, $urandom_range(8, 40), $urandom_range(2, 10), 0);
                2: random_phase(100, $urandom_range(1, 128), $urandom_range(1, 32),
                                $urandom_range(1));
                default: random_phase(100, 128, 32, 0);
            endcase
        end
    endtask

    initial begin
        cfg_cols = RST_COLUMNS; cfg_rows = RST_ROWS; cfg_attr = RST_ATTR; cfg_pass = 0;
        crow = 0; ccol = 0;
        foreach (cells[i]) cells[i] = '0;
        in_ch.valid = 1'b0; in_ch.opcode = 1'b0; in_ch.char_code = '0;
        in_ch.read_row = '0; in_ch.read_col = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 16; recv_idle_pct = 86;
        test_directed_controls();
        test_wrap_and_scroll();
        test_passthrough();
        test_extreme_geometry();
        test_random();

        in_ch.valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end
endmodule
